[design/tetf_pkg.sv]
// tetf_pkg: shared types and character constants for the text escape filter
// no dependencies; used by all tetf_* modules and the top level
`default_nettype none

package tetf_pkg;

    // character codes
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_BACKTICK  = 8'h60;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_QMARK     = 8'h3F;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] PRINT_LO       = 8'd32;
    localparam logic [7:0] PRINT_HI       = 8'd126;

    // length register
    localparam int          LEN_W         = 16;
    localparam int          CNT_W         = LEN_W + 1;
    localparam logic [15:0] MAX_LEN_RESET = 16'd256;

    // output sequence position, up to five bytes per request
    localparam int POS_W = 3;

    // descriptor of the bytes one input request produces
    typedef struct packed {
        logic       nonempty;  // request yields any output
        logic       esc;       // backslash goes first
        logic [7:0] ch;        // sanitized character
        logic       dots;      // ellipsis follows
        logic       eot;       // end of text
    } out_desc_t;

    // held input request
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } in_req_t;

endpackage

`default_nettype wire

[design/tetf_in_stage.sv]
// tetf_in_stage: input register for the text byte stream
// depends on tetf_pkg
`default_nettype none

module tetf_in_stage (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  [7:0]           in_char,
    input  wire                  in_eot,
    input  wire                  take,     // downstream consumes the held request
    output logic                 held,
    output tetf_pkg::in_req_t    req
);

    logic              valid_reg;
    logic              valid_next;
    tetf_pkg::in_req_t req_reg;

    // ready when empty or being emptied this cycle
    assign in_ready = !valid_reg || take;
    assign held     = valid_reg;
    assign req      = req_reg;

    // valid flag next value
    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.ch  <= in_char;
            req_reg.eot <= in_eot;
        end
    end

endmodule

`default_nettype wire

[design/tetf_sanitize.sv]
// tetf_sanitize: character classification, emitted count and cut-off state
// depends on tetf_pkg
`default_nettype none

module tetf_sanitize (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_wr_en,
    input  wire  [15:0]           cfg_wr_data,
    input  wire  tetf_pkg::in_req_t req,
    input  wire                   commit,   // request moves to the emitter
    output tetf_pkg::out_desc_t   desc
);

    logic [15:0]              max_len_reg;
    logic [tetf_pkg::CNT_W-1:0] count_reg;
    logic [tetf_pkg::CNT_W-1:0] count_next;
    logic                     cut_reg;
    logic                     cut_next;
    logic                     printable;
    logic                     ctrl_pass;
    logic                     esc;
    logic [7:0]               ch;
    logic [tetf_pkg::CNT_W-1:0] sum;
    logic                     hit;

    // classify the byte
    always_comb
    begin
        printable = (req.ch >= tetf_pkg::PRINT_LO) && (req.ch <= tetf_pkg::PRINT_HI);
        esc       = printable && (req.ch inside {tetf_pkg::CHAR_BACKSLASH,
            tetf_pkg::CHAR_DQUOTE, tetf_pkg::CHAR_SQUOTE, tetf_pkg::CHAR_BACKTICK});
        ctrl_pass = req.ch inside {tetf_pkg::CHAR_TAB, tetf_pkg::CHAR_LF,
            tetf_pkg::CHAR_CR};
        if (printable || ctrl_pass)
        begin
            ch = req.ch;
        end
        else
        begin
            ch = tetf_pkg::CHAR_QMARK;
        end
    end

    // running count and cut test
    assign sum = count_reg + (esc ? tetf_pkg::CNT_W'(2) : tetf_pkg::CNT_W'(1));
    assign hit = sum >= {1'b0, max_len_reg};

    assign desc.nonempty = !cut_reg;
    assign desc.esc      = esc;
    assign desc.ch       = ch;
    assign desc.dots     = hit;
    assign desc.eot      = req.eot;

    // state next values
    always_comb
    begin
        count_next = count_reg;
        cut_next   = cut_reg;
        if (commit)
        begin
            if (cut_reg)
            begin
                if (req.eot)
                begin
                    cut_next   = 1'b0;
                    count_next = '0;
                end
            end
            else if (req.eot)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = sum;
                cut_next   = hit;
            end
        end
    end

    // state and length registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= tetf_pkg::MAX_LEN_RESET;
            count_reg   <= '0;
            cut_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            cut_reg   <= cut_next;
        end
    end

endmodule

`default_nettype wire

[design/tetf_emit.sv]
// tetf_emit: result register that sends the bytes of one request, one per cycle while out_ready is high
// depends on tetf_pkg
`default_nettype none

module tetf_emit (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     load,
    input  wire  tetf_pkg::out_desc_t desc,
    output logic                    free,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [7:0]              out_char,
    output logic                    out_last
);

    logic                        busy_reg;
    logic                        busy_next;
    logic [tetf_pkg::POS_W-1:0]  pos_reg;
    logic [tetf_pkg::POS_W-1:0]  pos_next;
    tetf_pkg::out_desc_t         desc_reg;
    logic [tetf_pkg::POS_W-1:0]  final_pos;
    logic [tetf_pkg::POS_W-1:0]  char_pos;
    logic                        at_final;
    logic                        take;

    // position of the character and of the final byte
    assign char_pos  = desc_reg.esc ? tetf_pkg::POS_W'(1) : tetf_pkg::POS_W'(0);
    assign final_pos = char_pos + (desc_reg.dots ? tetf_pkg::POS_W'(3) : tetf_pkg::POS_W'(0));
    assign at_final  = pos_reg == final_pos;
    assign take      = busy_reg && out_ready;
    assign free      = !busy_reg || (out_ready && at_final);

    // output byte selection
    always_comb
    begin
        out_valid = busy_reg;
        out_last  = at_final && (desc_reg.dots || desc_reg.eot);
        if (desc_reg.esc && (pos_reg == '0))
        begin
            out_char = tetf_pkg::CHAR_BACKSLASH;
        end
        else if (pos_reg == char_pos)
        begin
            out_char = desc_reg.ch;
        end
        else
        begin
            out_char = tetf_pkg::CHAR_DOT;
        end
    end

    // sequencing
    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load && desc.nonempty)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
        end
        else if (take)
        begin
            if (at_final)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + tetf_pkg::POS_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    // descriptor register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc;
        end
    end

endmodule

`default_nettype wire

[design/text_escape_truncate_filter_unit.sv]
// text_escape_truncate_filter_unit: top level of the text escape and truncation filter
// depends on tetf_pkg, tetf_in_stage, tetf_sanitize, tetf_emit
//
//   channel   direction  signals                         payload
//   s_axis    in         tvalid tready tdata tlast       tdata[7:0] in_char, tlast end_of_text
//   m_axis    out        tvalid tready tdata tlast       tdata[7:0] out_char, tlast last
//   cfg       in         cfg_wr_en cfg_wr_data           max_len, written when enable is high
//
// one output byte leaves per cycle while m_axis_tready is high; the bytes a request yields:
// 1 for a plain byte, 2 for an escape, 4 or 5 with the ellipsis, none for a dropped byte
// the emitter's byte sequencer sends them from its result register, fed by the input register
// the input register takes the next request while the emitter sends its last byte
// reset clears the count, the cut-off flag and all valid flags; max_len returns to 256
`default_nettype none

module text_escape_truncate_filter_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] in_char
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data
);

    logic                held;
    logic                free;
    logic                commit;
    tetf_pkg::in_req_t   req;
    tetf_pkg::out_desc_t desc;

    // request moves on when the emitter can take it
    assign commit = held && free;

    // input register
    tetf_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_char  (s_axis_tdata),
        .in_eot   (s_axis_tlast),
        .take     (commit),
        .held     (held),
        .req      (req)
    );

    // classification and text state
    tetf_sanitize u_san (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .commit      (commit),
        .desc        (desc)
    );

    // result register and byte sequencer
    tetf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (commit),
        .desc      (desc),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[bench/tb.sv]
// tb: self-checking bench for text_escape_truncate_filter_unit, escaping and cut-off of text
// depends on tetf_pkg and the unit's rtl; predicts each output byte and compares in order
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 10;    // a dropped request may still sit in the unit
    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer on either side
    localparam int PHASE_ITEMS   = 70;    // least number of requests per random phase
    localparam int REPORT_MAX    = 10;

    // one predicted output byte
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_byte_t;

    // escape and cut-off predictor with the queue of bytes still owed by the unit
    class escape_checker;
        logic [15:0] max_len;
        logic [16:0] sent_count;
        bit          dropping;
        out_byte_t   pending_bytes[$];
        int unsigned mismatches;

        function new();
            max_len    = tetf_pkg::MAX_LEN_RESET;
            sent_count = '0;
            dropping   = 1'b0;
            mismatches = 0;
        endfunction

        // push one byte of the current request
        function void push_byte(logic [7:0] ch, logic last);
            out_byte_t b;
            b.ch   = ch;
            b.last = last;
            pending_bytes.push_back(b);
        endfunction

        // returns how many bytes the request produces
        function int predict_request(logic [7:0] ch, logic eot);
            int        n;
            out_byte_t tail;
            n = 0;
            // text already cut: swallow input up to its end
            if (dropping)
            begin
                if (eot)
                begin
                    dropping   = 1'b0;
                    sent_count = '0;
                end
                return 0;
            end
            // sanitize the character
            if (ch >= tetf_pkg::PRINT_LO && ch <= tetf_pkg::PRINT_HI)
            begin
                if (ch == tetf_pkg::CHAR_BACKSLASH || ch == tetf_pkg::CHAR_DQUOTE ||
                    ch == tetf_pkg::CHAR_SQUOTE || ch == tetf_pkg::CHAR_BACKTICK)
                begin
                    push_byte(tetf_pkg::CHAR_BACKSLASH, 1'b0);
                    n++;
                end
                push_byte(ch, 1'b0);
                n++;
            end
            else if (ch == tetf_pkg::CHAR_TAB || ch == tetf_pkg::CHAR_LF ||
                     ch == tetf_pkg::CHAR_CR)
            begin
                push_byte(ch, 1'b0);
                n++;
            end
            else
            begin
                push_byte(tetf_pkg::CHAR_QMARK, 1'b0);
                n++;
            end
            sent_count = sent_count + 17'(n);
            // length reached: ellipsis, last on the final dot
            if (sent_count >= {1'b0, max_len})
            begin
                push_byte(tetf_pkg::CHAR_DOT, 1'b0);
                push_byte(tetf_pkg::CHAR_DOT, 1'b0);
                push_byte(tetf_pkg::CHAR_DOT, 1'b1);
                if (eot)
                    sent_count = '0;
                else
                    dropping = 1'b1;
                return n + 3;
            end
            // plain end of text marks its final byte
            if (eot)
            begin
                tail      = pending_bytes.pop_back();
                tail.last = 1'b1;
                pending_bytes.push_back(tail);
                sent_count = '0;
            end
            return n;
        endfunction

        function void check_byte(logic [7:0] ch, logic last);
            out_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected output byte: char %h last %b", ch, last);
                return;
            end
            want = pending_bytes.pop_front();
            if (want.ch !== ch || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: expected char %h last %b, got char %h last %b",
                             want.ch, want.last, ch, last);
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;

    escape_checker checker_h   = new();
    bit            gaps_on     = 1'b1;
    int unsigned   idle_cycles = 0;
    int unsigned   items_sent  = 0;

    text_escape_truncate_filter_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // clock and reset
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
    end

    // output side: ready with random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (gaps_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    // output check and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                checker_h.check_byte(m_axis_tdata, m_axis_tlast);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("text_escape_truncate_filter_unit test failed");
                $finish;
            end
        end
    end

    // one input request, with an optional gap in front
    task automatic send_req(input logic [7:0] ch, input logic eot);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = ch;
        s_axis_tlast  = eot;
        do
            @(posedge clk);
        while (!s_axis_tready);
        void'(checker_h.predict_request(ch, eot));
        items_sent++;
    endtask

    // hold the sender until every predicted byte is out
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (checker_h.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        checker_h.max_len = value;
    endtask

    // random byte weighted toward printable and escaped characters
    function automatic logic [7:0] pick_char();
        logic [7:0] escapes[4];
        logic [7:0] controls[3];
        escapes  = '{tetf_pkg::CHAR_BACKSLASH, tetf_pkg::CHAR_DQUOTE,
                     tetf_pkg::CHAR_SQUOTE, tetf_pkg::CHAR_BACKTICK};
        controls = '{tetf_pkg::CHAR_TAB, tetf_pkg::CHAR_LF, tetf_pkg::CHAR_CR};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(tetf_pkg::PRINT_LO, tetf_pkg::PRINT_HI));
            4:          return escapes[$urandom_range(0, 3)];
            5:          return controls[$urandom_range(0, 2)];
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_text(input int len);
        for (int i = 0; i < len; i++)
            send_req(pick_char(), i == len - 1);
    endtask

    // stimulus
    initial
    begin
        logic [15:0] lens[6];
        logic [15:0] cur_len;
        int          text_len;
        int unsigned phase_start;
        lens = '{16'd1, 16'd5, 16'd65535, 16'd0, 16'd12, 16'd2};
        wait (rst_n === 1'b1);

        // every character class at reset length
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'h80, 1'b0);
        send_req(tetf_pkg::PRINT_LO, 1'b0);
        send_req(tetf_pkg::PRINT_HI, 1'b0);
        send_req(8'h7F, 1'b0);
        send_req(tetf_pkg::CHAR_BACKSLASH, 1'b0);
        send_req(tetf_pkg::CHAR_DQUOTE, 1'b0);
        send_req(tetf_pkg::CHAR_SQUOTE, 1'b0);
        send_req(tetf_pkg::CHAR_BACKTICK, 1'b0);
        send_req(tetf_pkg::CHAR_TAB, 1'b0);
        send_req(tetf_pkg::CHAR_LF, 1'b0);
        send_req(tetf_pkg::CHAR_CR, 1'b0);
        send_req(8'h41, 1'b1);

        // escape pair overshoots the limit, then input after the cut
        write_max_len(16'd2);
        send_req(8'h61, 1'b0);
        send_req(tetf_pkg::CHAR_DQUOTE, 1'b0);
        send_req(8'h78, 1'b0);
        send_req(8'h79, 1'b1);
        // cut on the end byte
        send_req(8'h62, 1'b0);
        send_req(8'h63, 1'b1);

        // zero length cuts after the first byte
        write_max_len(16'd0);
        send_req(8'h7A, 1'b1);
        send_req(tetf_pkg::CHAR_BACKSLASH, 1'b1);

        // length lowered below the count within a text
        write_max_len(16'd65535);
        send_req(8'h61, 1'b0);
        send_req(8'h62, 1'b0);
        send_req(8'h63, 1'b0);
        write_max_len(16'd1);
        send_req(8'h64, 1'b0);
        send_req(8'h65, 1'b1);

        // random texts over several lengths, no gaps in the last phase
        for (int p = 0; p < 6; p++)
        begin
            cur_len = (lens[p] == 16'd0) ? 16'($urandom_range(3, 40)) : lens[p];
            write_max_len(cur_len);
            if (p == 5)
                gaps_on = 1'b0;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                    text_len = $urandom_range(1, 40);
                else if (cur_len < 16'd13)
                    text_len = $urandom_range(1, cur_len + 3);
                else
                    text_len = $urandom_range(1, 16);
                send_text(text_len);
                // hold-off until the unit has emptied, mid-way through the second phase
                if (p == 1 && items_sent - phase_start >= PHASE_ITEMS / 2 &&
                    items_sent - phase_start < PHASE_ITEMS / 2 + text_len + 1)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (checker_h.mismatches == 0 && checker_h.pending_bytes.size() == 0)
            $display("text_escape_truncate_filter_unit test passed");
        else
            $display("text_escape_truncate_filter_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
